### hw/rtl/assert_macros.svh
// Assertion helper macros shared by the rasterizer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising edge, masked while reset is asserted.
`define ASSERT_CLK(label, clk_s, rstn_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
// Property checked at every rising edge, including during reset.
`define ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk_s, rstn_s, prop, msg)
`define ASSERT_ALWAYS(label, clk_s, prop, msg)
`endif
`endif

### hw/rtl/lpr_pkg.sv
// Package for the line pixel rasterizer: widths, canvas limits, FSM state
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package lpr_pkg;

  localparam int COORD_W    = 6;
  localparam int COLOUR_W   = 8;
  localparam int IN_DATA_W  = 4 * COORD_W + COLOUR_W;                      // 32
  localparam int OUT_BITS   = 2 * COORD_W + COLOUR_W;                      // 20
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;                    // 24
  // error term spans about +/- 2*(CANVAS_SIDE-1); one spare bit
  localparam int ERR_W      = COORD_W + 3;

  localparam int CANVAS_SIDE = 64;
  localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(CANVAS_SIDE - 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lpr_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture a new line command
    logic emit;   // push current pixel into the output register and advance
  } lpr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic at_end;     // current pixel is the end point
    logic out_stall;  // output register full and not taken this cycle
  } lpr_status_t;

endpackage

### hw/rtl/lpr_ctrl.sv
// Controller FSM for the line pixel rasterizer.
// Depends on lpr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  lpr_pkg::lpr_status_t st,
  output lpr_pkg::lpr_cmd_t    cmd
);

  lpr_pkg::lpr_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      lpr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = lpr_pkg::ST_RUN;
        end
      end
      lpr_pkg::ST_RUN: begin
        if (!st.out_stall) begin
          cmd.emit = 1'b1;
          if (st.at_end) begin
            state_nxt = lpr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_end_returns_idle, clk, rst_n,
    (cmd.emit && st.at_end) |=> (state_r == lpr_pkg::ST_IDLE),
    "controller did not return to idle after the end pixel")
  `ASSERT_CLK(a_no_load_and_emit, clk, rst_n, !(cmd.load && cmd.emit),
    "load and emit issued in the same cycle")
  `ASSERT_CLK(a_run_holds_on_stall, clk, rst_n,
    (state_r == lpr_pkg::ST_RUN && st.out_stall) |=> (state_r == lpr_pkg::ST_RUN),
    "controller left the run state while the output was stalled")

endmodule

### hw/rtl/lpr_dp.sv
// Datapath for the line pixel rasterizer: endpoint clamp, Bresenham error
// stepping and the output register. Depends on lpr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [lpr_pkg::IN_DATA_W-1:0]       in_tdata,
  input  lpr_pkg::lpr_cmd_t                   cmd,
  output lpr_pkg::lpr_status_t                st,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lpr_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast
);

  localparam int CW = lpr_pkg::COORD_W;
  localparam int EW = lpr_pkg::ERR_W;

  // unpacked command fields, clamped to the canvas
  logic [CW-1:0] sx_in, sy_in, ex_in, ey_in;
  logic [lpr_pkg::COLOUR_W-1:0] colour_in;

  always_comb begin
    sx_in = in_tdata[CW-1:0];
    sy_in = in_tdata[2*CW-1:CW];
    ex_in = in_tdata[3*CW-1:2*CW];
    ey_in = in_tdata[4*CW-1:3*CW];
    colour_in = in_tdata[4*CW +: lpr_pkg::COLOUR_W];
    if (sx_in > lpr_pkg::MAX_COORD) sx_in = lpr_pkg::MAX_COORD;
    if (sy_in > lpr_pkg::MAX_COORD) sy_in = lpr_pkg::MAX_COORD;
    if (ex_in > lpr_pkg::MAX_COORD) ex_in = lpr_pkg::MAX_COORD;
    if (ey_in > lpr_pkg::MAX_COORD) ey_in = lpr_pkg::MAX_COORD;
  end

  // walk state
  logic [CW-1:0] x_r, y_r, xe_r, ye_r, dx_r, dy_r;
  logic          sxn_r, syn_r;   // step negative
  logic signed [EW-1:0] err_r, err_nxt;
  logic [lpr_pkg::COLOUR_W-1:0] colour_r;

  // output register
  logic          out_valid_r;
  logic [CW-1:0] out_x_r, out_y_r;
  logic [lpr_pkg::COLOUR_W-1:0] out_colour_r;
  logic          out_last_r;

  // load-time deltas
  logic [CW-1:0] dx_ld, dy_ld;
  logic signed [EW-1:0] err_ld;

  always_comb begin
    dx_ld  = (ex_in > sx_in) ? (ex_in - sx_in) : (sx_in - ex_in);
    dy_ld  = (ey_in > sy_in) ? (ey_in - sy_in) : (sy_in - ey_in);
    err_ld = $signed({{(EW-CW){1'b0}}, dx_ld}) - $signed({{(EW-CW){1'b0}}, dy_ld});
  end

  // error tests on e2 = 2*err
  logic signed [EW:0]   e2, pdx, ndy;
  logic signed [EW-1:0] dx_e, dy_e;
  logic                 step_x, step_y;

  always_comb begin
    dx_e    = $signed({{(EW-CW){1'b0}}, dx_r});
    dy_e    = $signed({{(EW-CW){1'b0}}, dy_r});
    e2      = {err_r, 1'b0};
    pdx     = $signed({{(EW+1-CW){1'b0}}, dx_r});
    ndy     = -$signed({{(EW+1-CW){1'b0}}, dy_r});
    step_x  = e2 > ndy;
    step_y  = e2 < pdx;
    err_nxt = err_r - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);
  end

  always_comb begin
    st.at_end    = (x_r == xe_r) && (y_r == ye_r);
    st.out_stall = out_valid_r && !out_tready;
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= sx_in;
      y_r      <= sy_in;
      xe_r     <= ex_in;
      ye_r     <= ey_in;
      dx_r     <= dx_ld;
      dy_r     <= dy_ld;
      sxn_r    <= !(sx_in < ex_in);
      syn_r    <= !(sy_in < ey_in);
      err_r    <= err_ld;
      colour_r <= colour_in;
    end else if (cmd.emit && !st.at_end) begin
      err_r <= err_nxt;
      if (step_x) x_r <= sxn_r ? (x_r - 1'b1) : (x_r + 1'b1);
      if (step_y) y_r <= syn_r ? (y_r - 1'b1) : (y_r + 1'b1);
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_r      <= x_r;
      out_y_r      <= y_r;
      out_colour_r <= colour_r;
      out_last_r   <= st.at_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(lpr_pkg::OUT_DATA_W - lpr_pkg::OUT_BITS){1'b0}},
                       out_colour_r, out_y_r, out_x_r};

  `ASSERT_CLK(a_emit_into_free_reg, clk, rst_n,
    cmd.emit |-> !(out_valid_r && !out_tready),
    "pixel overwrote an output beat that was not taken")
  `ASSERT_CLK(a_out_on_canvas, clk, rst_n,
    out_valid_r |-> (out_x_r <= lpr_pkg::MAX_COORD && out_y_r <= lpr_pkg::MAX_COORD),
    "emitted pixel lies off the canvas")

endmodule

### hw/rtl/line_pixel_rasterizer_unit.sv
// Line pixel rasterizer: integer Bresenham line walker, top level.
// Depends on lpr_pkg, lpr_ctrl and lpr_dp.
`timescale 1ns / 1ps

// Usage:
//   in_*  : one beat is one line command. in_tdata holds, from bit 0 up,
//           start_x, start_y, end_x, end_y (6 bits each) and colour_in (8).
//   out_* : one beat per pixel. out_tdata holds pixel_x, pixel_y (6 bits
//           each) and colour_out (8), zero padded to 24 bits; out_tlast
//           marks the end point of the line.
//   A command yields max(|dx|,|dy|)+1 beats, 1 to 64. Coordinates above
//   the canvas edge are clamped to it.
// Timing:
//   The command beat is taken in idle; the first pixel is registered into
//   the output register from the run state that follows. Pixels then follow
//   one per cycle while out_tready stays high, set by the single error-update
//   step in the datapath. The next command is taken in the cycle after the
//   end pixel is registered, even while that pixel still waits on out_tready.
// Reset (rst_n low, synchronous): returns to idle, drops out_tvalid.
// Stall: with out_tready low the output beat holds and the line walk
//   pauses; no pixel is lost or repeated.
module line_pixel_rasterizer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], colour_in[31:24]
  input  logic [lpr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pixel_x[5:0], pixel_y[11:6], colour_out[19:12], zero [23:20]
  output logic [lpr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic                           out_tlast
);

  lpr_pkg::lpr_cmd_t    cmd;
  lpr_pkg::lpr_status_t st;

  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lpr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
